@@ rtl/chs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// chs_pkg: shared definitions for the chained hash set
// Sizes, derived widths, opcode and status codes, sequencer states.
// ----------------------------------------------------------------------------
package chs_pkg;

	// store geometry
	localparam int BUCKETS = 64;
	localparam int SLOTS   = 8;
	localparam int KEY_W   = 31;

	localparam int DEPTH   = BUCKETS * SLOTS;
	localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(SLOTS + 1);

	// bucket select is a plain mask when the bucket count is a power of two
	localparam bit BKT_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
	localparam logic [BKT_W-1:0] BKT_MASK   = BKT_W'(BUCKETS - 1);
	localparam logic [BKT_W-1:0] BKT_LAST   = BKT_W'(BUCKETS - 1);
	localparam logic [CNT_W-1:0] SLOTS_V    = CNT_W'(SLOTS);

	// otherwise: quotient = (key * DIV_MUL) >> DIV_SH, exact for every key;
	// only the low BKT_W quotient bits are needed for the remainder
	localparam int     DIV_SH   = KEY_W + $clog2(BUCKETS);
	localparam int     PROD_W   = DIV_SH + BKT_W;
	localparam longint DIV_CEIL = ((longint'(1) << DIV_SH) + longint'(BUCKETS - 1))
		/ longint'(BUCKETS);
	localparam logic [PROD_W-1:0] DIV_MUL    = PROD_W'(DIV_CEIL);
	localparam logic [BKT_W-1:0]  BKT_MOD_LO = BKT_W'(BUCKETS);

	// opcodes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef enum logic [2:0] {
		ST_NOT_FOUND = 3'd0,
		ST_FOUND     = 3'd1,
		ST_INSERTED  = 3'd2,
		ST_DUPLICATE = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_CNT_RD,
		S_CNT_LD,
		S_SCAN,
		S_WRITE,
		S_RESP
	} state_t;

endpackage : chs_pkg
`default_nettype wire

@@ rtl/chained_hash_set_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_set_core: bounded separate-chaining hash set
// Inserts and searches 31-bit keys in BUCKETS buckets of SLOTS slots each.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+---------------------------
//  in      | sink      | in_valid/in_stall  | op (1b), key (31b)
//  out     | source    | out_valid/out_stall| status (3b)
//
// Sequence: an accepted word passes S_HASH (only when BUCKETS is not a power
// of two), S_CNT_RD, S_CNT_LD, S_SCAN over the occupied slots of its bucket
// (at most SLOTS, a hit ends the scan), S_WRITE for a successful insert and
// S_RESP, where its result goes valid in the output register.
// The key comparator walks the slots one per cycle out of the key RAM read
// port. When BUCKETS is not a power of two the bucket comes from a
// reciprocal multiply at accept and the remainder step in S_HASH.
// Reset: arst_n clears the sequencer, then a clearing pass over all BUCKETS
// entries zeroes the per-bucket fill counts; no word is taken during that pass.
// Stalls: a result waits in the output register under out_stall; the next
// input word is not taken until the current result has moved into that
// register.
//
// Slots fill strictly in order and are never freed, so a per-bucket fill
// count (count RAM) stands in for per-slot valid bits.
// ----------------------------------------------------------------------------
module chained_hash_set_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// input channel
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      op,
	input  wire logic [chs_pkg::KEY_W-1:0] key,
	// output channel
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [2:0]                     status
);

	chs_pkg::state_t state_q, state_d;

	// per-word working registers
	logic                         op_q;
	logic [chs_pkg::KEY_W-1:0]    key_q;
	logic [chs_pkg::BKT_W-1:0]    bucket_q;
	logic [chs_pkg::PROD_W-1:0]   prod_q;
	logic [chs_pkg::ADDR_W-1:0]   base_q;
	logic [chs_pkg::CNT_W-1:0]    fill_q;
	logic [chs_pkg::CNT_W-1:0]    slot_q;
	chs_pkg::status_t             res_q;
	logic [chs_pkg::BKT_W-1:0]    clr_q;

	// output register
	logic                         out_valid_q;
	chs_pkg::status_t             status_q;

	// RAM ports
	logic                         kram_we, kram_re;
	logic [chs_pkg::ADDR_W-1:0]   kram_waddr, kram_raddr;
	logic [chs_pkg::KEY_W-1:0]    kram_rdata;
	logic                         cram_we, cram_re;
	logic [chs_pkg::BKT_W-1:0]    cram_waddr;
	logic [chs_pkg::CNT_W-1:0]    cram_wdata, cram_rdata;

	// sequencer outputs
	logic                         in_take;
	logic                         out_load;
	logic                         res_ld;
	chs_pkg::status_t             res_d;

	// shared datapath
	logic [chs_pkg::BKT_W-1:0]    quo_lo;
	logic [chs_pkg::BKT_W-1:0]    rem_calc;
	logic [chs_pkg::CNT_W-1:0]    slot_nx;
	logic [chs_pkg::ADDR_W-1:0]   base_d;
	logic                         hit;
	logic                         out_free;

	// remainder from the low quotient bits; exact since it is below BUCKETS
	assign quo_lo   = prod_q[chs_pkg::DIV_SH +: chs_pkg::BKT_W];
	assign rem_calc = key_q[chs_pkg::BKT_W-1:0] - quo_lo * chs_pkg::BKT_MOD_LO;

	assign base_d   = chs_pkg::ADDR_W'(bucket_q) * chs_pkg::ADDR_W'(chs_pkg::SLOTS);
	assign slot_nx  = slot_q + chs_pkg::CNT_W'(1);
	assign hit      = (kram_rdata == key_q);
	assign out_free = !out_valid_q || !out_stall;

	// ------------------------------------------------------------------
	// Memories
	// ------------------------------------------------------------------
	chs_ram #(
		.WIDTH(chs_pkg::KEY_W),
		.DEPTH(chs_pkg::DEPTH)
	) u_key_ram (
		.clk  (clk),
		.we   (kram_we),
		.waddr(kram_waddr),
		.wdata(key_q),
		.re   (kram_re),
		.raddr(kram_raddr),
		.rdata(kram_rdata)
	);

	chs_ram #(
		.WIDTH(chs_pkg::CNT_W),
		.DEPTH(chs_pkg::BUCKETS)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cram_we),
		.waddr(cram_waddr),
		.wdata(cram_wdata),
		.re   (cram_re),
		.raddr(bucket_q),
		.rdata(cram_rdata)
	);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chs_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_take    = 1'b0;
		out_load   = 1'b0;
		res_ld     = 1'b0;
		res_d      = chs_pkg::ST_NOT_FOUND;
		kram_we    = 1'b0;
		kram_waddr = base_q + chs_pkg::ADDR_W'(fill_q);
		kram_re    = 1'b0;
		kram_raddr = base_q;
		cram_we    = 1'b0;
		cram_waddr = bucket_q;
		cram_wdata = fill_q + chs_pkg::CNT_W'(1);
		cram_re    = 1'b0;

		unique case (state_q)
			chs_pkg::S_CLEAR: begin
				cram_we    = 1'b1;
				cram_waddr = clr_q;
				cram_wdata = '0;
				if (clr_q == chs_pkg::BKT_LAST) begin
					state_d = chs_pkg::S_IDLE;
				end
			end
			chs_pkg::S_IDLE: begin
				if (in_valid) begin
					in_take = 1'b1;
					state_d = chs_pkg::BKT_POW2 ? chs_pkg::S_CNT_RD : chs_pkg::S_HASH;
				end
			end
			chs_pkg::S_HASH: begin
				state_d = chs_pkg::S_CNT_RD;
			end
			chs_pkg::S_CNT_RD: begin
				cram_re = 1'b1;
				state_d = chs_pkg::S_CNT_LD;
			end
			chs_pkg::S_CNT_LD: begin
				// fetch slot 0 while the fill count lands
				if (cram_rdata != '0) begin
					kram_re = 1'b1;
					state_d = chs_pkg::S_SCAN;
				end else if (op_q == chs_pkg::OP_SEARCH) begin
					res_ld  = 1'b1;
					res_d   = chs_pkg::ST_NOT_FOUND;
					state_d = chs_pkg::S_RESP;
				end else begin
					state_d = chs_pkg::S_WRITE;
				end
			end
			chs_pkg::S_SCAN: begin
				kram_raddr = base_q + chs_pkg::ADDR_W'(slot_nx);
				if (hit) begin
					res_ld  = 1'b1;
					res_d   = (op_q == chs_pkg::OP_SEARCH)
						? chs_pkg::ST_FOUND : chs_pkg::ST_DUPLICATE;
					state_d = chs_pkg::S_RESP;
				end else if (slot_nx != fill_q) begin
					kram_re = 1'b1;
				end else if (op_q == chs_pkg::OP_SEARCH) begin
					res_ld  = 1'b1;
					res_d   = chs_pkg::ST_NOT_FOUND;
					state_d = chs_pkg::S_RESP;
				end else if (fill_q == chs_pkg::SLOTS_V) begin
					res_ld  = 1'b1;
					res_d   = chs_pkg::ST_FULL;
					state_d = chs_pkg::S_RESP;
				end else begin
					state_d = chs_pkg::S_WRITE;
				end
			end
			chs_pkg::S_WRITE: begin
				kram_we = 1'b1;
				cram_we = 1'b1;
				res_ld  = 1'b1;
				res_d   = chs_pkg::ST_INSERTED;
				state_d = chs_pkg::S_RESP;
			end
			chs_pkg::S_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = chs_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = chs_pkg::S_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != chs_pkg::S_IDLE);

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == chs_pkg::S_CLEAR) begin
				clr_q <= clr_q + chs_pkg::BKT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q     <= op;
			key_q    <= key;
			bucket_q <= key[chs_pkg::BKT_W-1:0] & chs_pkg::BKT_MASK;
			prod_q   <= chs_pkg::PROD_W'(key) * chs_pkg::DIV_MUL;
		end
		if (state_q == chs_pkg::S_HASH) begin
			bucket_q <= rem_calc;
		end
		if (state_q == chs_pkg::S_CNT_RD) begin
			base_q <= base_d;
		end
		if (state_q == chs_pkg::S_CNT_LD) begin
			fill_q <= cram_rdata;
			slot_q <= '0;
		end
		if (state_q == chs_pkg::S_SCAN) begin
			slot_q <= slot_nx;
		end
		if (res_ld) begin
			res_q <= res_d;
		end
		if (out_load) begin
			status_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// a bucket never reports more keys than it has slots
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == chs_pkg::S_CNT_LD) |-> (cram_rdata <= chs_pkg::SLOTS_V))
		else $error("fill count above slot count");

	// the scan never looks past the filled slots
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == chs_pkg::S_SCAN) |-> (slot_q < fill_q))
		else $error("scan beyond filled slots");

	// only an insert into a bucket with room writes the key store
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		kram_we |-> (op_q == chs_pkg::OP_INSERT && fill_q < chs_pkg::SLOTS_V))
		else $error("bad key store write");

	// a store write is always followed by an inserted report
	a_write_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == chs_pkg::S_WRITE)
			|=> (state_q == chs_pkg::S_RESP && res_q == chs_pkg::ST_INSERTED))
		else $error("write not reported as inserted");

endmodule : chained_hash_set_core
`default_nettype wire

@@ rtl/chs_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// chs_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module chs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule : chs_ram
`default_nettype wire
